FILE: hw/rtl/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam logic [CNT_W-1:0] NUM_BLOCKS_CNT = CNT_W'(NUM_BLOCKS);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b1;

    // Policy codes. The unused code behaves as first fit.
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    // Input word.
    typedef struct packed {
        logic        kind;
        logic [3:0]  load_index;
        logic [15:0] size_value;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic        granted;
        logic [3:0]  block_index;
        logic [15:0] remaining;
    } t_out_item;

    // Write request into the free-size table.
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      addr;
        logic [SIZE_WIDTH-1:0] data;
    } t_tbl_wr;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/fpba_table.sv
// Free-size table: one write port, one read port at the scan index.
module fpba_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpba_pkg::t_tbl_wr             i_wr,
    input  logic [fpba_pkg::IDX_W-1:0]      i_rd_addr,
    output logic [fpba_pkg::SIZE_WIDTH-1:0] o_rd_data
);
    import fpba_pkg::*;

    logic [SIZE_WIDTH-1:0] r_size [NUM_BLOCKS];

    // Entries clear on reset and take one write per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                r_size[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_size[i_wr.addr] <= i_wr.data;
        end
    end

    // The scan reads one entry per cycle.
    assign o_rd_data = r_size[i_rd_addr];

endmodule

FILE: hw/rtl/fpba_ctrl.sv
// Sequencer and shared compare unit that write loads and scan the table for a request.
module fpba_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  fpba_pkg::t_in_item              i_item,
    input  logic [1:0]                      i_policy,
    input  logic [fpba_pkg::CNT_W-1:0]        i_active,
    input  logic [fpba_pkg::SIZE_WIDTH-1:0]   i_rd_data,
    output logic [fpba_pkg::IDX_W-1:0]        o_rd_addr,
    output fpba_pkg::t_tbl_wr               o_wr,
    output logic                            o_busy,
    output logic                            o_result_valid,
    output fpba_pkg::t_out_item             o_result
);
    import fpba_pkg::*;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_last, n_last;
    logic [IDX_W-1:0]      r_pick, n_pick;
    logic [SIZE_WIDTH-1:0] r_best, n_best;
    logic [SIZE_WIDTH-1:0] r_req, n_req;
    logic [1:0]            r_mode, n_mode;
    logic                  r_found, n_found;
    logic                  r_valid, n_valid;
    t_out_item             r_out, n_out;

    logic [CNT_W-1:0]      limit;
    logic                  fits;
    logic                  better;
    logic                  first_mode;
    logic [SIZE_WIDTH-1:0] left;

    // Number of entries searched, clamped to the table depth.
    assign limit = (i_active > NUM_BLOCKS_CNT) ? NUM_BLOCKS_CNT : i_active;

    // Shared compare unit: fit test and policy compare against the best so far.
    assign fits       = (i_rd_data >= r_req);
    assign first_mode = (r_mode != POL_BEST) && (r_mode != POL_WORST);
    assign better     = ((r_mode == POL_BEST) && (i_rd_data < r_best)) ||
                        ((r_mode == POL_WORST) && (i_rd_data > r_best));
    assign left       = r_best - r_req;

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_found <= n_found;
        end
        r_idx  <= n_idx;
        r_last <= n_last;
        r_pick <= n_pick;
        r_best <= n_best;
        r_req  <= n_req;
        r_mode <= n_mode;
        r_out  <= n_out;
    end

    // Next state, table writes and result word.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_last  = r_last;
        n_pick  = r_pick;
        n_best  = r_best;
        n_req   = r_req;
        n_mode  = r_mode;
        n_found = r_found;
        n_valid = 1'b0;
        n_out   = r_out;
        o_wr    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    if (i_item.kind == KIND_LOAD) begin
                        // A load writes the entry and answers at once.
                        n_valid           = 1'b1;
                        n_out.granted     = 1'b0;
                        n_out.block_index = i_item.load_index;
                        n_out.remaining   = '0;
                        if ({1'b0, i_item.load_index} < NUM_BLOCKS_CNT) begin
                            o_wr.en         = 1'b1;
                            o_wr.addr       = i_item.load_index[IDX_W-1:0];
                            o_wr.data       = i_item.size_value;
                            n_out.remaining = i_item.size_value;
                        end
                    end else if (limit == '0) begin
                        // Nothing to search: refuse.
                        n_valid = 1'b1;
                        n_out   = '0;
                    end else begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                        n_last  = IDX_W'(limit - CNT_W'(1));
                        n_req   = i_item.size_value;
                        n_mode  = i_policy;
                        n_found = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                // One entry per cycle; first fit stops at its first hit.
                if (fits && (!r_found || better)) begin
                    n_found = 1'b1;
                    n_pick  = r_idx;
                    n_best  = i_rd_data;
                end
                if ((fits && first_mode) || (r_idx == r_last)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_DONE: begin
                // Charge the chosen block, if any, and report.
                n_state = ST_IDLE;
                n_valid = 1'b1;
                n_out   = '0;
                if (r_found) begin
                    o_wr.en           = 1'b1;
                    o_wr.addr         = r_pick;
                    o_wr.data         = left;
                    n_out.granted     = 1'b1;
                    n_out.block_index = 4'(r_pick);
                    n_out.remaining   = left;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr      = r_idx;
    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_out;

endmodule

FILE: hw/rtl/fit_policy_block_allocator_unit.sv
// Top level of the fit-policy block allocator: configuration and wiring.
//
//  channel   signals                                  handshake
//  input     start, busy, i_item                      start high while busy low
//  result    o_result_valid, o_result                 one-cycle strobe, no stall
//  config    i_cfg_we, i_cfg_idx, i_cfg_data          write on we, no wait
//
// A load is written at once; its result strobes in the next cycle and start
// may come again at once. A request scans one table entry per cycle through
// the shared compare unit, up to active_blocks entries (first fit stops at
// the first hit), then charges the chosen block, if any, in a done state;
// busy is high meanwhile.
// Synchronous reset clears the table to zero, policy to first fit and
// active_blocks to 16. The receiver cannot stall results.
module fit_policy_block_allocator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  fpba_pkg::t_in_item                 i_item,
    output logic                               o_result_valid,
    output fpba_pkg::t_out_item                o_result,
    input  logic                               i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fpba_pkg::*;

    logic [1:0]            r_policy;
    logic [CNT_W-1:0]      r_active;
    logic                  accept;
    logic [IDX_W-1:0]      rd_addr;
    logic [SIZE_WIDTH-1:0] rd_data;
    t_tbl_wr               tbl_wr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
            r_active <= NUM_BLOCKS_CNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[1:0];
                CFG_ACTIVE: r_active <= i_cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign accept = start && !busy;

    fpba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_item),
        .i_policy       (r_policy),
        .i_active       (r_active),
        .i_rd_data      (rd_data),
        .o_rd_addr      (rd_addr),
        .o_wr           (tbl_wr),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    fpba_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

FILE: hw/rtl/fpba_checker.sv
// Port-level checker for the fit-policy block allocator, bound to the top.
module fpba_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input fpba_pkg::t_in_item  i_item,
    input logic                o_result_valid,
    input fpba_pkg::t_out_item o_result
);
    import fpba_pkg::*;

    // A load answers in the next cycle, echoing its index, never a grant.
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.kind == KIND_LOAD)
        |=> o_result_valid && !o_result.granted &&
            (o_result.block_index == $past(i_item.load_index)) &&
            (o_result.remaining == $past(i_item.size_value)))
        else $error("load result missing or wrong");

    // A grant only comes out of a scan.
    a_grant_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.granted |-> $past(busy))
        else $error("grant without a scan");

    // No result appears in the first cycle of a scan.
    a_no_result_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(busy) |-> !o_result_valid)
        else $error("result during scan start");

    // A refused request reports all zero fields.
    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && $past(busy) && !o_result.granted
        |-> (o_result.block_index == '0) && (o_result.remaining == '0))
        else $error("refusal with nonzero fields");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
